[src/worker_lease_health_tracker_core_macros.svh]
`ifndef WORKER_LEASE_HEALTH_TRACKER_CORE_MACROS_SVH
`define WORKER_LEASE_HEALTH_TRACKER_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled during reset.
`define WLHT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, clocked on clk and disabled during reset.
`define WLHT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/wlht_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package wlht_pkg;

    localparam int WORKERS_DEF   = 16;
    localparam int TIME_BITS_DEF = 32;
    localparam int CFG_ADDR_W    = 4;
    localparam int TOTAL_W       = 32;

    localparam logic [7:0]  POISON_RST = 8'd3;
    localparam logic [30:0] LEASE_RST  = 31'd30000;
    localparam logic [7:0]  RETRY_RST  = 8'd3;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_POISON = 2'd0;
    localparam logic [1:0] REG_LEASE  = 2'd1;
    localparam logic [1:0] REG_RETRY  = 2'd2;

    typedef enum logic [2:0] {
        OP_LIVE     = 3'd0,
        OP_START    = 3'd1,
        OP_OUTCOME  = 3'd2,
        OP_VERDICT  = 3'd3,
        OP_TAKEOVER = 3'd4,
        OP_ERASE    = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        HEALTH_OK      = 2'd0,
        HEALTH_QUAR    = 2'd1,
        HEALTH_EXPIRED = 2'd2
    } health_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef struct packed {
        logic [7:0]  poison_threshold;
        logic [30:0] lease_time;
        logic [7:0]  max_takeover_retries;
    } cfg_t;

    typedef struct packed {
        logic clear;
        logic accept;
        logic exec;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic out_blocked;
    } stat_t;

endpackage

`default_nettype wire

[src/wlht_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none

module wlht_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [wlht_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                      pwdata,
    output logic      [31:0]                      prdata,
    output logic                                  pready,
    output wlht_pkg::cfg_t                        cfg
);
    import wlht_pkg::*;

    logic [7:0]  poison_reg;
    logic [30:0] lease_reg;
    logic [7:0]  retry_reg;
    logic        wr_strobe;

    assign pready    = 1'b1;
    assign wr_strobe = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poison_reg <= POISON_RST;
            lease_reg  <= LEASE_RST;
            retry_reg  <= RETRY_RST;
        end
        else if (wr_strobe)
        begin
            unique case (paddr[3:2])
                REG_POISON: poison_reg <= pwdata[7:0];
                REG_LEASE:  lease_reg  <= pwdata[30:0];
                REG_RETRY:  retry_reg  <= pwdata[7:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_POISON: prdata = {24'd0, poison_reg};
            REG_LEASE:  prdata = {1'b0, lease_reg};
            REG_RETRY:  prdata = {24'd0, retry_reg};
            default:    prdata = 32'd0;
        endcase
    end

    assign cfg.poison_threshold     = poison_reg;
    assign cfg.lease_time           = lease_reg;
    assign cfg.max_takeover_retries = retry_reg;

endmodule

`default_nettype wire

[src/wlht_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module wlht_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire wlht_pkg::stat_t stat,
    output wlht_pkg::cmd_t       cmd
);
    import wlht_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // The result register must be free, or be emptied at this edge.
                if (!stat.out_blocked)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/wlht_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "worker_lease_health_tracker_core_macros.svh"

module wlht_dp #(
    parameter int WORKERS   = wlht_pkg::WORKERS_DEF,
    parameter int TIME_BITS = wlht_pkg::TIME_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire wlht_pkg::cmd_t                cmd,
    output wlht_pkg::stat_t                    stat,
    input  wire wlht_pkg::cfg_t                cfg,
    input  wire logic [2:0]                    operation,
    input  wire logic [3:0]                    worker,
    input  wire logic                          succeeded,
    input  wire logic [7:0]                    attempt,
    input  wire logic [31:0]                   now_time,
    input  wire logic                          out_stall,
    output logic                               out_valid,
    output logic [1:0]                         health,
    output logic                               takeover_allowed,
    output logic [wlht_pkg::TOTAL_W-1:0]       quarantine_total,
    output logic [wlht_pkg::TOTAL_W-1:0]       expiry_total
);
    import wlht_pkg::*;

    localparam int IDX_W = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int CMP_W = (TIME_BITS > 31) ? TIME_BITS : 31;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORKERS - 1);

    // Record table, one row per worker.
    logic                 mem_valid [WORKERS];
    logic [TIME_BITS-1:0] mem_last  [WORKERS];
    logic                 mem_hold  [WORKERS];
    logic                 mem_exp   [WORKERS];
    logic [7:0]           mem_fc    [WORKERS];
    logic                 mem_quar  [WORKERS];

    logic                 rd_valid_reg;
    logic [TIME_BITS-1:0] rd_last_reg;
    logic                 rd_hold_reg;
    logic                 rd_exp_reg;
    logic [7:0]           rd_fc_reg;
    logic                 rd_quar_reg;

    logic [2:0]           op_reg;
    logic                 ok_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 succ_reg;
    logic [7:0]           attempt_reg;
    logic [TIME_BITS-1:0] now_reg;

    logic [IDX_W-1:0]     clr_cnt_reg;
    logic                 out_valid_reg;
    logic [1:0]           health_reg;
    logic                 allowed_reg;
    logic [TOTAL_W-1:0]   quarantine_cnt_reg;
    logic [TOTAL_W-1:0]   quarantine_cnt_next;
    logic [TOTAL_W-1:0]   expiry_cnt_reg;
    logic [TOTAL_W-1:0]   expiry_cnt_next;

    logic [IDX_W+3:0]     worker_ext;
    logic [IDX_W-1:0]     in_idx;
    logic                 in_ok;
    logic [TIME_BITS+31:0] now_ext;

    logic                 wr_en;
    logic [IDX_W-1:0]     wr_idx;
    logic                 wr_valid;
    logic                 write_req;

    logic [TIME_BITS-1:0] eff_last;
    logic                 eff_hold;
    logic                 eff_exp;
    logic [7:0]           eff_fc;
    logic                 eff_quar;
    logic [TIME_BITS-1:0] silent;
    logic                 expired;
    logic [7:0]           fc_inc;

    logic                 nv_valid;
    logic [TIME_BITS-1:0] nv_last;
    logic                 nv_hold;
    logic                 nv_exp;
    logic [7:0]           nv_fc;
    logic                 nv_quar;
    logic [1:0]           h;
    logic                 allow;
    logic                 q_bump;
    logic                 e_bump;

    assign worker_ext = {{IDX_W{1'b0}}, worker};
    assign in_idx     = worker_ext[IDX_W-1:0];
    assign in_ok      = 32'(worker) < 32'(WORKERS);
    assign now_ext    = {{TIME_BITS{1'b0}}, now_time};

    // Capture the word and start the table read at the accepting edge.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg       <= operation;
            ok_reg       <= in_ok;
            idx_reg      <= in_idx;
            succ_reg     <= succeeded;
            attempt_reg  <= attempt;
            now_reg      <= now_ext[TIME_BITS-1:0];
            rd_valid_reg <= mem_valid[in_idx];
            rd_last_reg  <= mem_last[in_idx];
            rd_hold_reg  <= mem_hold[in_idx];
            rd_exp_reg   <= mem_exp[in_idx];
            rd_fc_reg    <= mem_fc[in_idx];
            rd_quar_reg  <= mem_quar[in_idx];
        end
        if (wr_en)
        begin
            mem_valid[wr_idx] <= wr_valid;
            mem_last[wr_idx]  <= nv_last;
            mem_hold[wr_idx]  <= nv_hold;
            mem_exp[wr_idx]   <= nv_exp;
            mem_fc[wr_idx]    <= nv_fc;
            mem_quar[wr_idx]  <= nv_quar;
        end
    end

    assign wr_en    = cmd.clear || (cmd.exec && write_req);
    assign wr_idx   = cmd.clear ? clr_cnt_reg : idx_reg;
    assign wr_valid = cmd.clear ? 1'b0 : nv_valid;

    always_comb
    begin
        // An entry that is not valid behaves as freshly created at this time.
        eff_last = rd_valid_reg ? rd_last_reg : now_reg;
        eff_hold = rd_valid_reg && rd_hold_reg;
        eff_exp  = rd_valid_reg && rd_exp_reg;
        eff_fc   = rd_valid_reg ? rd_fc_reg : 8'd0;
        eff_quar = rd_valid_reg && rd_quar_reg;

        silent  = now_reg - rd_last_reg;
        expired = CMP_W'(silent) > CMP_W'(cfg.lease_time);
        fc_inc  = (eff_fc == 8'hFF) ? eff_fc : eff_fc + 8'd1;

        nv_valid  = 1'b1;
        nv_last   = eff_last;
        nv_hold   = eff_hold;
        nv_exp    = eff_exp;
        nv_fc     = eff_fc;
        nv_quar   = eff_quar;
        write_req = 1'b0;
        h         = HEALTH_OK;
        allow     = 1'b0;
        q_bump    = 1'b0;
        e_bump    = 1'b0;

        if (op_reg == OP_TAKEOVER)
        begin
            allow = attempt_reg <= cfg.max_takeover_retries;
        end
        else if (ok_reg)
        begin
            unique case (op_reg)
                OP_LIVE:
                begin
                    write_req = 1'b1;
                    nv_last   = now_reg;
                    nv_exp    = 1'b0;
                    h         = eff_quar ? HEALTH_QUAR : HEALTH_OK;
                end
                OP_START:
                begin
                    write_req = 1'b1;
                    nv_last   = now_reg;
                    nv_hold   = 1'b1;
                end
                OP_OUTCOME:
                begin
                    write_req = 1'b1;
                    nv_last   = now_reg;
                    nv_hold   = 1'b0;
                    nv_exp    = 1'b0;
                    if (succ_reg)
                    begin
                        nv_fc = 8'd0;
                        h     = eff_quar ? HEALTH_QUAR : HEALTH_OK;
                    end
                    else
                    begin
                        nv_fc = fc_inc;
                        if ((fc_inc >= cfg.poison_threshold) && !eff_quar)
                        begin
                            nv_quar = 1'b1;
                            q_bump  = 1'b1;
                            h       = HEALTH_QUAR;
                        end
                    end
                end
                OP_VERDICT:
                begin
                    // A verdict never creates a record; it writes the row back unchanged
                    // apart from the expiry mark.
                    write_req = 1'b1;
                    nv_valid  = rd_valid_reg;
                    if (rd_valid_reg)
                    begin
                        if (rd_quar_reg)
                        begin
                            h = HEALTH_QUAR;
                        end
                        else if (rd_hold_reg && expired)
                        begin
                            h = HEALTH_EXPIRED;
                            if (!rd_exp_reg)
                            begin
                                nv_exp = 1'b1;
                                e_bump = 1'b1;
                            end
                        end
                    end
                end
                OP_ERASE:
                begin
                    write_req = 1'b1;
                    nv_valid  = 1'b0;
                end
                default:
                begin
                    write_req = 1'b0;
                end
            endcase
        end
    end

    assign quarantine_cnt_next = (q_bump && (quarantine_cnt_reg != '1))
                               ? quarantine_cnt_reg + TOTAL_W'(1) : quarantine_cnt_reg;
    assign expiry_cnt_next     = (e_bump && (expiry_cnt_reg != '1))
                               ? expiry_cnt_reg + TOTAL_W'(1) : expiry_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg        <= '0;
            out_valid_reg      <= 1'b0;
            quarantine_cnt_reg <= '0;
            expiry_cnt_reg     <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
            end
            if (cmd.exec)
            begin
                out_valid_reg      <= 1'b1;
                quarantine_cnt_reg <= quarantine_cnt_next;
                expiry_cnt_reg     <= expiry_cnt_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            health_reg  <= h;
            allowed_reg <= allow;
        end
    end

    assign stat.clear_done  = clr_cnt_reg == LAST_IDX;
    assign stat.out_blocked = out_valid_reg && out_stall;

    assign out_valid        = out_valid_reg;
    assign health           = health_reg;
    assign takeover_allowed = allowed_reg;
    // The totals only move when a result is loaded, so they can drive the outputs directly.
    assign quarantine_total = quarantine_cnt_reg;
    assign expiry_total     = expiry_cnt_reg;

    `WLHT_ASSERT_NXT(a_qtot_monotonic, 1'b1, quarantine_cnt_reg >= $past(quarantine_cnt_reg))
    `WLHT_ASSERT_NXT(a_qtot_hold, !cmd.exec, $stable(quarantine_cnt_reg))
    `WLHT_ASSERT_NXT(a_etot_hold, !cmd.exec, $stable(expiry_cnt_reg))
    `WLHT_ASSERT_NXT(a_exp_verdict, cmd.exec && op_reg != OP_VERDICT, health_reg != HEALTH_EXPIRED)
    `WLHT_ASSERT_IMP(a_exec_out_free, cmd.exec, !(out_valid_reg && out_stall))

endmodule

`default_nettype wire

[src/worker_lease_health_tracker_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Payload
// input     in_valid / in_stall  operation, worker, succeeded, attempt, now_time
// output    out_valid/out_stall  health, takeover_allowed, quarantine_total, expiry_total
// config    APB psel/penable     paddr, pwdata, prdata, pready
//
// Each word's record is read at the accepting edge and written back, with the result
// loaded, once the result register is free, through the single table port.
// After reset a clearing pass marks every record empty; in_stall is high throughout it.
// A new word is accepted while a result still waits, but it is not completed until
// the result register has been taken.

module worker_lease_health_tracker_core #(
    parameter int WORKERS   = wlht_pkg::WORKERS_DEF,
    parameter int TIME_BITS = wlht_pkg::TIME_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [2:0]                       operation,
    input  wire logic [3:0]                       worker,
    input  wire logic                             succeeded,
    input  wire logic [7:0]                       attempt,
    input  wire logic [31:0]                      now_time,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [1:0]                            health,
    output logic                                  takeover_allowed,
    output logic [wlht_pkg::TOTAL_W-1:0]          quarantine_total,
    output logic [wlht_pkg::TOTAL_W-1:0]          expiry_total,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [wlht_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                      pwdata,
    output logic      [31:0]                      prdata,
    output logic                                  pready
);
    import wlht_pkg::*;

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t stat;

    wlht_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wlht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    wlht_dp #(
        .WORKERS   (WORKERS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .cfg              (cfg),
        .operation        (operation),
        .worker           (worker),
        .succeeded        (succeeded),
        .attempt          (attempt),
        .now_time         (now_time),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .health           (health),
        .takeover_allowed (takeover_allowed),
        .quarantine_total (quarantine_total),
        .expiry_total     (expiry_total)
    );

endmodule

`default_nettype wire
